// File: hw/rtl/assert_macros.svh
// Assertion helpers shared by the checker files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, off while reset is asserted.
`define ASSERT_SAME(name, ck, rst_n, pre, post) \
	name: assert property (@(posedge ck) disable iff (!(rst_n)) (pre) |-> (post)) \
		else $error("assertion failed");

// Next-cycle implication, off while reset is asserted.
`define ASSERT_NEXT(name, ck, rst_n, pre, post) \
	name: assert property (@(posedge ck) disable iff (!(rst_n)) (pre) |=> (post)) \
		else $error("assertion failed");

`endif

// File: hw/rtl/llra_pkg.sv
package llra_pkg;

	// Row storage geometry
	localparam int MAX_ROWS   = 64;
	localparam int WIDTH_BITS = 16;
	localparam int ROW_IDX_W  = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
	localparam int ROW_CNT_W  = $clog2(MAX_ROWS + 1);

	// Fixed field widths
	localparam int ITEM_W   = 12;
	localparam int ROWS_W   = 7;
	localparam int PAD_W    = 8;
	localparam int CHOSEN_W = 6;
	localparam int WIDEST_W = 16;
	localparam int CFG_W    = 8;
	localparam int REG_IDX_W = 1;

	// Register reset values
	localparam logic [ROWS_W-1:0] ROWS_RESET = ROWS_W'(1);
	localparam logic [PAD_W-1:0]  PAD_RESET  = PAD_W'(4);

	// Register indexes
	localparam logic [REG_IDX_W-1:0] REG_ACTIVE_ROWS = 1'b0;
	localparam logic [REG_IDX_W-1:0] REG_PAD_WIDTH   = 1'b1;

	localparam logic [32:0] WIDTH_MAX_EXT = (33'd1 << WIDTH_BITS) - 33'd1;
	localparam logic [32:0] WIDEST_MAX_EXT = 33'h0_FFFF;

	typedef logic [WIDTH_BITS-1:0] row_w_t;
	typedef logic [ROW_IDX_W-1:0]  row_idx_t;
	typedef logic [ROW_CNT_W-1:0]  row_cnt_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_LAST,
		ST_WRITE
	} state_t;

	// Controller to datapath
	typedef struct packed {
		logic start;
		logic rd_en;
		logic wr_en;
	} cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic rd_last;
		logic out_free;
	} status_t;

	// Item width plus pad, clipped to the row range
	function automatic row_w_t sat_inc(logic [ITEM_W-1:0] w, logic [PAD_W-1:0] p);
		logic [ITEM_W:0] s;
		s = {1'b0, w} + (ITEM_W + 1)'(p);
		if (33'(s) > WIDTH_MAX_EXT)
			return '1;
		return row_w_t'(s);
	endfunction

	// Row width sum, clipped to the row range
	function automatic row_w_t sat_row(row_w_t a, row_w_t b);
		logic [WIDTH_BITS:0] s;
		s = {1'b0, a} + {1'b0, b};
		if (s[WIDTH_BITS])
			return '1;
		return s[WIDTH_BITS-1:0];
	endfunction

	// Row width reported on the result port
	function automatic logic [WIDEST_W-1:0] clip_widest(row_w_t m);
		if (33'(m) > WIDEST_MAX_EXT)
			return '1;
		return WIDEST_W'(m);
	endfunction

endpackage

// File: hw/rtl/llra_ram.sv
module llra_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 64,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	// Write one entry, read one entry with registered data
	always_ff @(posedge clk) begin
		if (we)
			mem_q[waddr] <= wdata;
		if (re)
			rd_data_q <= mem_q[raddr];
	end

	assign rdata = rd_data_q;

endmodule

// File: hw/rtl/llra_ctrl.sv
module llra_ctrl import llra_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    in_valid,
	output logic    in_ready,
	input  status_t status,
	output cmd_t    cmd
);

	state_t state_q, state_d;

	// Hold the state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ST_IDLE;
		else
			state_q <= state_d;
	end

	// Sequence one item: scan the rows, drain the read, write back
	always_comb begin
		state_d  = state_q;
		in_ready = 1'b0;
		cmd      = '0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.start = 1'b1;
					state_d   = ST_SCAN;
				end
			end
			ST_SCAN: begin
				cmd.rd_en = 1'b1;
				if (status.rd_last)
					state_d = ST_LAST;
			end
			ST_LAST: begin
				state_d = ST_WRITE;
			end
			ST_WRITE: begin
				if (status.out_free) begin
					cmd.wr_en = 1'b1;
					state_d   = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

// File: hw/rtl/llra_dp.sv
module llra_dp import llra_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [REG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data,
	input  logic [ITEM_W-1:0]    item_width,
	input  logic                 last_item,
	input  cmd_t                 cmd,
	output status_t              status,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic [CHOSEN_W-1:0]  row_chosen,
	output logic                 set_done,
	output logic [WIDEST_W-1:0]  widest_row
);

	// Configuration and control state
	logic [ROWS_W-1:0]   active_rows_q;
	logic [PAD_W-1:0]    pad_width_q;
	logic                set_starting_q;
	logic [MAX_ROWS-1:0] valid_q;
	logic                out_valid_q;
	logic                rd_v_s1;
	row_idx_t            rd_cnt_q;

	// Item payload and scan results
	logic [ITEM_W-1:0]   item_q;
	logic                last_q;
	logic [PAD_W-1:0]    pad_q;
	logic [PAD_W-1:0]    set_pad_q;
	row_cnt_t            n_q;
	row_idx_t            idx_s1;
	row_idx_t            best_q;
	row_w_t              best_val_q;
	row_w_t              max_q;
	logic [CHOSEN_W-1:0] row_q;
	logic                done_q;
	logic [WIDEST_W-1:0] widest_q;

	logic [8:0] rows_ext;
	row_cnt_t   n_clamped;
	row_w_t     ram_rdata;
	row_w_t     rd_data;
	row_w_t     new_w;
	row_w_t     widest;

	// Clamp the row count to 1..MAX_ROWS
	always_comb begin
		rows_ext = 9'(active_rows_q);
		if (rows_ext == 9'd0)
			n_clamped = row_cnt_t'(1);
		else if (rows_ext > 9'(MAX_ROWS))
			n_clamped = row_cnt_t'(MAX_ROWS);
		else
			n_clamped = row_cnt_t'(rows_ext);
	end

	llra_ram #(
		.WIDTH(WIDTH_BITS),
		.DEPTH(MAX_ROWS)
	) u_rows (
		.clk  (clk),
		.we   (cmd.wr_en),
		.waddr(best_q),
		.wdata(new_w),
		.re   (cmd.rd_en),
		.raddr(rd_cnt_q),
		.rdata(ram_rdata)
	);

	// Rows not written since set start read as the set's pad
	always_comb begin
		rd_data = valid_q[idx_s1] ? ram_rdata : row_w_t'(set_pad_q);
		new_w   = sat_row(best_val_q, sat_inc(item_q, pad_q));
		widest  = (new_w > max_q) ? new_w : max_q;
	end

	assign status.rd_last  = (row_cnt_t'(rd_cnt_q) == (n_q - row_cnt_t'(1)));
	assign status.out_free = !out_valid_q || out_ready;

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_rows_q  <= ROWS_RESET;
			pad_width_q    <= PAD_RESET;
			set_starting_q <= 1'b1;
			valid_q        <= '0;
			out_valid_q    <= 1'b0;
			rd_v_s1        <= 1'b0;
			rd_cnt_q       <= '0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_ACTIVE_ROWS: active_rows_q <= cfg_data[ROWS_W-1:0];
					REG_PAD_WIDTH:   pad_width_q   <= cfg_data[PAD_W-1:0];
					default: ;
				endcase
			end
			rd_v_s1 <= cmd.rd_en;
			if (cmd.start) begin
				rd_cnt_q <= '0;
				if (set_starting_q) begin
					valid_q        <= '0;
					set_starting_q <= 1'b0;
				end
			end else if (cmd.rd_en) begin
				rd_cnt_q <= rd_cnt_q + row_idx_t'(1);
			end
			if (cmd.wr_en) begin
				valid_q[best_q] <= 1'b1;
				out_valid_q     <= 1'b1;
				if (last_q)
					set_starting_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Latch the item, track minimum and maximum over the scan, load the result
	always_ff @(posedge clk) begin
		if (cmd.start) begin
			item_q <= item_width;
			last_q <= last_item;
			pad_q  <= pad_width_q;
			n_q    <= n_clamped;
			if (set_starting_q)
				set_pad_q <= pad_width_q;
		end
		idx_s1 <= rd_cnt_q;
		if (rd_v_s1) begin
			if (idx_s1 == '0 || rd_data < best_val_q) begin
				best_q     <= idx_s1;
				best_val_q <= rd_data;
			end
			if (idx_s1 == '0 || rd_data > max_q)
				max_q <= rd_data;
		end
		if (cmd.wr_en) begin
			row_q    <= CHOSEN_W'(best_q);
			done_q   <= last_q;
			widest_q <= last_q ? clip_widest(widest) : '0;
		end
	end

	assign out_valid  = out_valid_q;
	assign row_chosen = row_q;
	assign set_done   = done_q;
	assign widest_row = widest_q;

endmodule

// File: hw/rtl/least_loaded_row_assign.sv
// Least-loaded row assignment.
// Input channel (in_valid/in_ready) takes one item: item_width and last_item.
// Output channel (out_valid/out_ready) returns one result per item: the row
// it went to, set_done on the last item of a set, and then the widest row.
// Configuration: write cfg_data to register cfg_index while cfg_we is high;
// index 0 is active_rows, index 1 is pad_width. Write only while idle.
// Each item scans the N active rows (N = active_rows clamped to 1..64)
// through the single read port of the row-width memory, one row per cycle.
// After the scan come the LAST and WRITE states; the result becomes valid and
// in_ready returns as the write-back leaves WRITE, so items never overlap.
// The first item of a set starts every row at pad_width; no clearing pass is
// needed, per-row valid bits stand in for the stored widths.
// Reset: active_rows is 1, pad_width is 4, no result is pending and the
// next item opens a new set.
// A stalled result waits in the output register; the block still accepts
// the next item and holds its write-back until the register is free.
module least_loaded_row_assign import llra_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [REG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic [ITEM_W-1:0]    item_width,
	input  logic                 last_item,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic [CHOSEN_W-1:0]  row_chosen,
	output logic                 set_done,
	output logic [WIDEST_W-1:0]  widest_row
);

	cmd_t    cmd;
	status_t status;

	llra_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.status  (status),
		.cmd     (cmd)
	);

	llra_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.item_width(item_width),
		.last_item (last_item),
		.cmd       (cmd),
		.status    (status),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.row_chosen(row_chosen),
		.set_done  (set_done),
		.widest_row(widest_row)
	);

endmodule

// File: hw/rtl/llra_checker.sv
`include "assert_macros.svh"

module llra_checker import llra_pkg::*; (
	input logic                clk,
	input logic                arst_n,
	input logic                in_valid,
	input logic                in_ready,
	input logic                out_valid,
	input logic                out_ready,
	input logic [CHOSEN_W-1:0] row_chosen,
	input logic                set_done,
	input logic [WIDEST_W-1:0] widest_row
);

	// A stalled result holds its fields
	`ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid && $stable(row_chosen) && $stable(set_done) && $stable(widest_row))

	// Widest row is reported only on the last item of a set
	`ASSERT_SAME(a_widest_zero, clk, arst_n, out_valid && !set_done, widest_row == '0)

	// An accepted item keeps the block busy for the next cycle
	`ASSERT_NEXT(a_busy_after_accept, clk, arst_n, in_valid && in_ready, !in_ready)

	// A new result appears only after a busy cycle
	`ASSERT_SAME(a_result_after_busy, clk, arst_n, $rose(out_valid), !$past(in_ready))

endmodule

bind least_loaded_row_assign llra_checker u_chk (.*);

// File: tb/tb.sv
import llra_pkg::*;

// Tracks the row loads the way the block should, and holds the results still owed
class row_load_board;
	typedef struct {
		logic [CHOSEN_W-1:0] row;
		logic                done;
		logic [WIDEST_W-1:0] widest;
	} row_result_t;

	logic [ROWS_W-1:0]     rows_reg;
	logic [PAD_W-1:0]      pad_reg;
	logic [WIDTH_BITS-1:0] load [MAX_ROWS];
	bit                    opening;
	row_result_t           due [$];
	int                    errors;

	function new();
		rows_reg = ROWS_RESET;
		pad_reg = PAD_RESET;
		foreach (load[i])
			load[i] = WIDTH_BITS'(PAD_RESET);
		opening = 1'b1;
		errors = 0;
	endfunction

	function void write_reg(logic [REG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
		case (idx)
			REG_ACTIVE_ROWS: rows_reg = data[ROWS_W-1:0];
			REG_PAD_WIDTH:   pad_reg = data[PAD_W-1:0];
			default: ;
		endcase
	endfunction

	// Place one accepted item on the least loaded row and queue its result
	function void note_item(logic [ITEM_W-1:0] w, logic last);
		int                  n;
		int                  best;
		int                  i;
		logic [WIDTH_BITS:0] sum;
		row_result_t         r;
		if (rows_reg == 0)
			n = 1;
		else if (rows_reg > MAX_ROWS)
			n = MAX_ROWS;
		else
			n = int'(rows_reg);
		// a new set starts every row, active or not, at the pad
		if (opening) begin
			foreach (load[j])
				load[j] = WIDTH_BITS'(pad_reg);
			opening = 1'b0;
		end
		// lowest index wins a tie
		best = 0;
		for (i = 1; i < n; i++)
			if (load[i] < load[best])
				best = i;
		sum = {1'b0, load[best]} + (WIDTH_BITS + 1)'(w) + (WIDTH_BITS + 1)'(pad_reg);
		load[best] = sum[WIDTH_BITS] ? '1 : sum[WIDTH_BITS-1:0];
		r.row = CHOSEN_W'(best);
		r.done = last;
		r.widest = '0;
		if (last) begin
			for (i = 0; i < n; i++)
				if (load[i] > r.widest)
					r.widest = WIDEST_W'(load[i]);
			opening = 1'b1;
		end
		due = {due, r};
	endfunction

	// Compare one accepted result with the oldest one owed
	function void check_result(logic [CHOSEN_W-1:0] row, logic done, logic [WIDEST_W-1:0] widest);
		row_result_t e;
		if (due.size() == 0) begin
			$error("result with no item pending: row_chosen=%0d set_done=%0d widest_row=%0d",
				row, done, widest);
			errors++;
			return;
		end
		e = due.pop_front();
		if (row !== e.row) begin
			$error("row_chosen: expected %0d, got %0d", e.row, row);
			errors++;
		end
		if (done !== e.done) begin
			$error("set_done: expected %0d, got %0d", e.done, done);
			errors++;
		end
		if (widest !== e.widest) begin
			$error("widest_row: expected %0d, got %0d", e.widest, widest);
			errors++;
		end
	endfunction
endclass

module tb;
	localparam int DIRECTED_ITEMS = 25;
	localparam int RANDOM_ITEMS   = 625;
	localparam int STALL_LIMIT    = 4000;
	localparam int HOLD_CYCLES    = 600;

	logic                 clk;
	logic                 arst_n;
	logic                 cfg_we;
	logic [REG_IDX_W-1:0] cfg_index;
	logic [CFG_W-1:0]     cfg_data;
	logic                 in_valid;
	logic                 in_ready;
	logic [ITEM_W-1:0]    item_width;
	logic                 last_item;
	logic                 out_valid;
	logic                 out_ready;
	logic [CHOSEN_W-1:0]  row_chosen;
	logic                 set_done;
	logic [WIDEST_W-1:0]  widest_row;

	row_load_board board;
	int            items_taken = 0;
	int            idle_cycles = 0;
	int            burst_left = 0;

	least_loaded_row_assign uut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.item_width (item_width),
		.last_item  (last_item),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.row_chosen (row_chosen),
		.set_done   (set_done),
		.widest_row (widest_row)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	// Offer one item and hold it until taken
	task automatic send_item(input logic [ITEM_W-1:0] w, input logic last);
		in_valid <= 1'b1;
		item_width <= w;
		last_item <= last;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		board.note_item(w, last);
		items_taken++;
	endtask

	// Drop valid with junk on the payload, unless n is zero
	task automatic hold_input(input int n);
		if (n > 0) begin
			in_valid <= 1'b0;
			item_width <= ITEM_W'($urandom);
			last_item <= 1'($urandom_range(0, 1));
			repeat (n) @(posedge clk);
		end
	endtask

	// Drain every owed result so the block is idle
	task automatic settle();
		in_valid <= 1'b0;
		@(posedge clk);
		while (board.due.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		board.write_reg(idx, data);
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	// End bursts at random and insert a gap
	task automatic pace();
		burst_left--;
		if (burst_left <= 0) begin
			burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 80) : $urandom_range(1, 10);
			hold_input($urandom_range(1, 20));
		end
	endtask

	function automatic logic [ITEM_W-1:0] pick_width();
		case ($urandom_range(0, 9))
			0: return '0;
			1: return '1;
			2, 3: return ITEM_W'($urandom_range(0, 15));
			default: return ITEM_W'($urandom);
		endcase
	endfunction

	// Mostly few rows; now and then zero, all, or past the top
	function automatic logic [CFG_W-1:0] pick_rows();
		case ($urandom_range(0, 9))
			0: return '0;
			1: return CFG_W'($urandom_range(65, 255));
			2: return CFG_W'(MAX_ROWS);
			3: return CFG_W'($urandom_range(9, 63));
			default: return CFG_W'($urandom_range(1, 8));
		endcase
	endfunction

	// Check each accepted result
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready)
			board.check_result(row_chosen, set_done, widest_row);
	end

	// Stop the run if neither channel moves for too long
	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready))
			idle_cycles = 0;
		else if (idle_cycles >= STALL_LIMIT) begin
			$display("FAIL");
			$finish;
		end else
			idle_cycles = idle_cycles + 1;
	end

	// Receiver: stall on a changing duty pattern, with one long hold-off
	initial begin
		int pct;
		int span;
		bit held;
		held = 1'b0;
		out_ready <= 1'b0;
		@(posedge arst_n);
		forever begin
			if (!held && items_taken >= 150) begin
				held = 1'b1;
				out_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end
			case ($urandom_range(0, 3))
				0: pct = 100;
				1: pct = 80;
				2: pct = 50;
				default: pct = 15;
			endcase
			span = $urandom_range(5, 120);
			repeat (span) begin
				out_ready <= ($urandom_range(1, 100) <= pct);
				@(posedge clk);
			end
		end
	end

	// Sender and configuration
	initial begin
		int len;
		int split;
		int k;
		board = new();
		arst_n <= 1'b0;
		cfg_we <= 1'b0;
		cfg_index <= '0;
		cfg_data <= '0;
		in_valid <= 1'b0;
		item_width <= '0;
		last_item <= 1'b0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset values: one row, pad of four
		send_item('0, 1'b0);
		send_item('1, 1'b1);
		settle();

		// zero rows acts as one, no pad
		write_reg(REG_ACTIVE_ROWS, '0);
		write_reg(REG_PAD_WIDTH, '0);
		send_item('0, 1'b1);
		settle();

		// row count past the top clamps to all rows, widest pad
		write_reg(REG_ACTIVE_ROWS, CFG_W'(200));
		write_reg(REG_PAD_WIDTH, '1);
		send_item('1, 1'b0);
		send_item(ITEM_W'(1), 1'b1);
		settle();

		// widen the row count in the middle of a set
		write_reg(REG_ACTIVE_ROWS, CFG_W'(2));
		write_reg(REG_PAD_WIDTH, CFG_W'(8));
		send_item(ITEM_W'(100), 1'b0);
		send_item(ITEM_W'(100), 1'b0);
		settle();
		write_reg(REG_ACTIVE_ROWS, CFG_W'(4));
		send_item(ITEM_W'(50), 1'b0);
		send_item(ITEM_W'(7), 1'b1);
		settle();

		// drive a single row into saturation
		write_reg(REG_ACTIVE_ROWS, CFG_W'(1));
		write_reg(REG_PAD_WIDTH, '1);
		for (k = 0; k < 16; k++)
			send_item('1, k == 15);
		settle();

		// random sets with bursty input
		while (items_taken < DIRECTED_ITEMS + RANDOM_ITEMS) begin
			if ($urandom_range(0, 1) == 0) begin
				settle();
				write_reg(REG_ACTIVE_ROWS, pick_rows());
				write_reg(REG_PAD_WIDTH, CFG_W'($urandom_range(0, 255)));
			end
			len = ($urandom_range(0, 5) == 0) ? $urandom_range(17, 40) : $urandom_range(1, 12);
			split = (len > 1 && $urandom_range(0, 7) == 0) ? $urandom_range(1, len - 1) : 0;
			for (k = 0; k < len; k++) begin
				if (split != 0 && k == split) begin
					settle();
					write_reg(REG_ACTIVE_ROWS, pick_rows());
				end
				send_item(pick_width(), k == len - 1);
				pace();
			end
		end

		settle();
		repeat (80) @(posedge clk);
		if (board.errors == 0 && board.due.size() == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end
endmodule
